// ----- rtl/mono_bitmap_stream_decoder_macros.svh -----
// assertion macros for the monochrome bitmap stream decoder
// each macro expects clk and arst_n in scope
`ifndef MONO_BITMAP_STREAM_DECODER_MACROS_SVH
`define MONO_BITMAP_STREAM_DECODER_MACROS_SVH
`ifndef NO_ASSERTIONS
// expression holds at every clock edge out of reset
`define MBSD_ASSERT_HOLDS(label, expr, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (expr)) else $error(msg);
// antecedent at one edge implies consequent at the next edge
`define MBSD_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define MBSD_ASSERT_HOLDS(label, expr, msg)
`define MBSD_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ----- rtl/mbsd_pkg.sv -----
package mbsd_pkg;

	localparam int SIDE_BITS = 12;
	localparam int FIFO_DEPTH = 4;

	localparam logic [SIDE_BITS-1:0] MAX_SIDE_RESET = 12'd4095;

	// header characters
	localparam logic [7:0] CH_FMT_NEW   = 8'h79; // 'y'
	localparam logic [7:0] CH_FMT_OLD16 = 8'h7A; // 'z'
	localparam logic [7:0] CH_FMT_OLD32 = 8'h78; // 'x'
	localparam logic [7:0] CH_MAGIC     = 8'h7A; // 'z'
	localparam logic [7:0] CH_SPACE     = 8'h20; // ' '
	localparam logic [7:0] CH_DEPTH_ONE = 8'h21; // ' ' + 1

	typedef enum logic [1:0] {
		KIND_PIXELS = 2'd0,
		KIND_HEADER = 2'd1,
		KIND_STATUS = 2'd2
	} kind_t;

	typedef enum logic [1:0] {
		ST_OK      = 2'd0,
		ST_TRUNC   = 2'd1,
		ST_INVALID = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PAD_8  = 2'd0,
		PAD_16 = 2'd1,
		PAD_32 = 2'd2
	} pad_t;

	typedef enum logic [2:0] {
		PH_HEADER = 3'b001,
		PH_PIXELS = 3'b010,
		PH_IGNORE = 3'b100
	} phase_t;

	typedef struct packed {
		kind_t                kind;
		logic [7:0]           pixel_bits;
		logic [3:0]           pixel_count;
		logic [SIDE_BITS-1:0] row_index;
		logic [SIDE_BITS-1:0] column_start;
		logic [SIDE_BITS-1:0] image_width;
		logic [SIDE_BITS-1:0] image_height;
		status_t              status;
		logic                 run_last;
	} result_t;

	// up to two results from one item, first is emitted first
	typedef struct packed {
		logic [1:0] count;
		result_t    first;
		result_t    second;
	} push_t;

endpackage

// ----- rtl/mono_bitmap_stream_decoder.sv -----
// monochrome bitmap stream decoder
// s_axis takes the file one byte per item, tlast on the final byte of the file.
// the header is parsed as it arrives; once it is complete a header item
// (tuser 1) carries width and height, then one pixel item (tuser 0) per image
// byte, row padding bytes dropped, and lastly a status item (tuser 2):
// ok, truncated or invalid. after a status, bytes are swallowed until tlast.
// m_axis tlast marks the last result item caused by one input byte.
// an input byte is registered in the input stage, decoded into a four-entry
// result queue and shown on m_axis from its head. throughput: one byte per
// cycle while the queue has room; a byte giving two results (header or pixels,
// then a status) puts both in the queue. s_axis_tready drops only while the
// queue has fewer than two free entries, so a stalled receiver fills the queue
// and then holds off the sender, with no item lost. max_side is to be written
// through cfg_we/cfg_wdata only while idle; the block does not enforce this.
// reset clears the parser to await a header, empties the queue and sets
// max_side to 4095; no clearing pass is needed.
`include "mono_bitmap_stream_decoder_macros.svh"

module mono_bitmap_stream_decoder #(
	parameter int NEW_HEADER_BYTES = 8,
	parameter int OLD_HEADER_BYTES = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	// input bytes
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,   // [7:0] data_byte
	input  logic        s_axis_tlast,   // last_byte
	// result items
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// [7:0] pixel_bits, [11:8] pixel_count, [23:12] row_index,
	// [35:24] column_start, [47:36] image_width, [59:48] image_height,
	// [61:60] status, [63:62] zero
	output logic [63:0] m_axis_tdata,
	output logic [1:0]  m_axis_tuser,   // kind
	output logic        m_axis_tlast,   // run_last
	// configuration
	input  logic        cfg_we,
	input  logic [mbsd_pkg::SIDE_BITS-1:0] cfg_wdata  // max_side
);

	// input register stage
	logic       valid_s1;
	logic [7:0] byte_s1;
	logic       last_s1;

	logic [mbsd_pkg::SIDE_BITS-1:0] max_side_q;

	logic              step;      // the registered byte is decoded this cycle
	logic              room_two;  // queue can take a double result
	mbsd_pkg::push_t   push;
	mbsd_pkg::result_t head;

	assign step = valid_s1 && room_two;
	assign s_axis_tready = !valid_s1 || step;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			byte_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_side_q <= mbsd_pkg::MAX_SIDE_RESET;
		end else if (cfg_we) begin
			max_side_q <= cfg_wdata;
		end
	end

	mbsd_parser #(
		.NEW_HEADER_BYTES (NEW_HEADER_BYTES),
		.OLD_HEADER_BYTES (OLD_HEADER_BYTES)
	) u_parser (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.data_byte (byte_s1),
		.last_byte (last_s1),
		.max_side  (max_side_q),
		.push      (push)
	);

	mbsd_out_fifo u_out_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.room_two  (room_two),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_res   (head)
	);

	// pack the head of the queue onto the output bus
	assign m_axis_tdata = {2'b00, head.status, head.image_height, head.image_width,
		head.column_start, head.row_index, head.pixel_count, head.pixel_bits};
	assign m_axis_tuser = head.kind;
	assign m_axis_tlast = head.run_last;

	// a status always closes the results of its byte
	`MBSD_ASSERT_HOLDS(a_status_is_last,
		!(m_axis_tvalid && m_axis_tuser == mbsd_pkg::KIND_STATUS) || m_axis_tlast,
		"status item without tlast")
	// pixel items carry one to eight pixels
	`MBSD_ASSERT_HOLDS(a_pixel_count_range,
		!(m_axis_tvalid && m_axis_tuser == mbsd_pkg::KIND_PIXELS) ||
		(m_axis_tdata[11:8] != 4'd0 && m_axis_tdata[11:8] <= 4'd8),
		"pixel item with bad pixel count")
	// an accepted byte is held in the input stage
	`MBSD_ASSERT_NEXT(a_accept_loads_s1, s_axis_tvalid && s_axis_tready, valid_s1,
		"accepted byte not registered")

endmodule

// ----- rtl/mbsd_parser.sv -----
module mbsd_parser #(
	parameter int NEW_HEADER_BYTES = 8,
	parameter int OLD_HEADER_BYTES = 6
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                step,
	input  logic [7:0]                          data_byte,
	input  logic                                last_byte,
	input  logic [mbsd_pkg::SIDE_BITS-1:0]      max_side,
	output mbsd_pkg::push_t                     push
);

	localparam int HdrMax = (NEW_HEADER_BYTES > OLD_HEADER_BYTES) ?
		NEW_HEADER_BYTES : OLD_HEADER_BYTES;
	localparam int HC_W = $clog2(HdrMax + 1);
	localparam int SB = mbsd_pkg::SIDE_BITS;

	// header byte positions
	localparam int IdxFormat = 0;
	localparam int IdxMagic  = 1;
	localparam int IdxWHi    = 2;
	localparam int IdxWLo    = 3;
	localparam int IdxHHi    = 4;
	localparam int IdxHLo    = 5;
	localparam int IdxDepth  = 6;

	mbsd_pkg::phase_t phase_q, phase_d;
	logic [HC_W-1:0]  hc_q, hc_d;
	logic [7:0]       first_q, first_d;
	mbsd_pkg::pad_t   pad_q, pad_d;
	logic [SB-1:0]    width_q, width_d;
	logic [SB-1:0]    height_q, height_d;
	logic [7:0]       chars_q, chars_d;
	logic [9:0]       rbi_q, rbi_d;
	logic [SB-1:0]    row_q, row_d;

	// two 6-bit characters offset from space, zero when out of range
	function automatic logic [SB-1:0] side_value(input logic [7:0] c0, input logic [7:0] c1);
		logic [14:0] v;
		v = ({7'd0, c0 - mbsd_pkg::CH_SPACE} << 6) + {7'd0, c1 - mbsd_pkg::CH_SPACE};
		if (c0 < mbsd_pkg::CH_SPACE || c1 < mbsd_pkg::CH_SPACE || v > 15'd4095) begin
			return '0;
		end
		return v[SB-1:0];
	endfunction

	function automatic mbsd_pkg::result_t status_res(input mbsd_pkg::status_t st);
		mbsd_pkg::result_t r;
		r = '0;
		r.kind = mbsd_pkg::KIND_STATUS;
		r.status = st;
		r.run_last = 1'b1;
		return r;
	endfunction

	always_comb begin
		logic [HC_W-1:0] hlen;
		logic            magic_bad;
		logic            bad;
		logic [12:0]     col;
		logic [SB-1:0]   rem;
		logic [3:0]      cnt;
		logic [12:0]     w7;
		logic [12:0]     w15;
		logic [12:0]     w31;
		logic [9:0]      rbytes;
		logic [9:0]      rbi_inc;
		logic            pix;
		mbsd_pkg::result_t r;

		phase_d  = phase_q;
		hc_d     = hc_q;
		first_d  = first_q;
		pad_d    = pad_q;
		width_d  = width_q;
		height_d = height_q;
		chars_d  = chars_q;
		rbi_d    = rbi_q;
		row_d    = row_q;
		push     = '0;
		hlen     = '0;
		magic_bad = 1'b0;
		bad      = 1'b0;
		col      = {rbi_q, 3'b000};
		rem      = '0;
		cnt      = '0;
		w7       = {1'b0, width_q} + 13'd7;
		w15      = {1'b0, width_q} + 13'd15;
		w31      = {1'b0, width_q} + 13'd31;
		rbytes   = '0;
		rbi_inc  = rbi_q + 10'd1;
		pix      = 1'b0;
		r        = '0;

		unique case (phase_q)
			mbsd_pkg::PH_IGNORE: begin
				if (last_byte) begin
					phase_d = mbsd_pkg::PH_HEADER;
					hc_d = '0;
				end
			end
			mbsd_pkg::PH_HEADER: begin
				if (hc_q == HC_W'(IdxFormat)) begin
					chars_d = data_byte;
				end else if (hc_q == HC_W'(IdxMagic)) begin
					if (data_byte != mbsd_pkg::CH_MAGIC) begin
						magic_bad = 1'b1;
					end else if (chars_q == mbsd_pkg::CH_FMT_NEW) begin
						pad_d = mbsd_pkg::PAD_8;
					end else if (chars_q == mbsd_pkg::CH_FMT_OLD16) begin
						pad_d = mbsd_pkg::PAD_16;
					end else if (chars_q == mbsd_pkg::CH_FMT_OLD32) begin
						pad_d = mbsd_pkg::PAD_32;
					end else begin
						magic_bad = 1'b1;
					end
				end else if (hc_q == HC_W'(IdxWHi) || hc_q == HC_W'(IdxHHi)) begin
					first_d = data_byte;
				end else if (hc_q == HC_W'(IdxWLo)) begin
					width_d = side_value(first_q, data_byte);
				end else if (hc_q == HC_W'(IdxHLo)) begin
					height_d = side_value(first_q, data_byte);
				end else if (hc_q == HC_W'(IdxDepth) && pad_q == mbsd_pkg::PAD_8) begin
					first_d = data_byte;
				end
				hc_d = hc_q + HC_W'(1);
				hlen = (pad_d == mbsd_pkg::PAD_8) ? HC_W'(NEW_HEADER_BYTES) :
					HC_W'(OLD_HEADER_BYTES);
				bad = width_d == '0 || height_d == '0 ||
					width_d > max_side || height_d > max_side ||
					(pad_d == mbsd_pkg::PAD_8 && first_d != mbsd_pkg::CH_DEPTH_ONE);
				if (magic_bad) begin
					push.count = 2'd1;
					push.first = status_res(mbsd_pkg::ST_INVALID);
				end else if (hc_d >= hlen) begin
					if (bad) begin
						push.count = 2'd1;
						push.first = status_res(mbsd_pkg::ST_INVALID);
					end else begin
						r.kind = mbsd_pkg::KIND_HEADER;
						r.image_width = width_d;
						r.image_height = height_d;
						r.run_last = !last_byte;
						push.count = 2'd1;
						push.first = r;
						phase_d = mbsd_pkg::PH_PIXELS;
						rbi_d = '0;
						row_d = '0;
						if (last_byte) begin
							push.count = 2'd2;
							push.second = status_res(mbsd_pkg::ST_TRUNC);
						end
					end
				end else if (last_byte) begin
					push.count = 2'd1;
					push.first = status_res(mbsd_pkg::ST_TRUNC);
				end
				// a status ends this file
				if (push.count != 2'd0 && (magic_bad || bad || last_byte)) begin
					hc_d = '0;
					if (last_byte) begin
						phase_d = mbsd_pkg::PH_HEADER;
					end else begin
						phase_d = mbsd_pkg::PH_IGNORE;
					end
				end
			end
			mbsd_pkg::PH_PIXELS: begin
				if (col < {1'b0, width_q}) begin
					pix = 1'b1;
					rem = width_q - col[SB-1:0];
					cnt = (rem > SB'(8)) ? 4'd8 : rem[3:0];
					r.kind = mbsd_pkg::KIND_PIXELS;
					r.pixel_bits = data_byte & ~(8'hFF >> cnt);
					r.pixel_count = cnt;
					r.row_index = row_q;
					r.column_start = col[SB-1:0];
				end
				unique case (pad_q)
					mbsd_pkg::PAD_8:  rbytes = w7[12:3];
					mbsd_pkg::PAD_16: rbytes = {w15[12:4], 1'b0};
					default:          rbytes = {w31[12:5], 2'b00};
				endcase
				if (rbi_inc >= rbytes) begin
					rbi_d = '0;
					row_d = row_q + SB'(1);
				end else begin
					rbi_d = rbi_inc;
				end
				if (row_d >= height_q || last_byte) begin
					if (pix) begin
						push.count = 2'd2;
						push.first = r;
						push.second = status_res((row_d >= height_q) ?
							mbsd_pkg::ST_OK : mbsd_pkg::ST_TRUNC);
					end else begin
						push.count = 2'd1;
						push.first = status_res((row_d >= height_q) ?
							mbsd_pkg::ST_OK : mbsd_pkg::ST_TRUNC);
					end
					hc_d = '0;
					if (last_byte) begin
						phase_d = mbsd_pkg::PH_HEADER;
					end else begin
						phase_d = mbsd_pkg::PH_IGNORE;
					end
				end else if (pix) begin
					r.run_last = 1'b1;
					push.count = 2'd1;
					push.first = r;
				end
			end
			default: begin
				phase_d = mbsd_pkg::PH_HEADER;
				hc_d = '0;
			end
		endcase

		if (!step) begin
			push.count = 2'd0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q  <= mbsd_pkg::PH_HEADER;
			hc_q     <= '0;
			first_q  <= '0;
			pad_q    <= mbsd_pkg::PAD_8;
			width_q  <= '0;
			height_q <= '0;
			chars_q  <= '0;
			rbi_q    <= '0;
			row_q    <= '0;
		end else if (step) begin
			phase_q  <= phase_d;
			hc_q     <= hc_d;
			first_q  <= first_d;
			pad_q    <= pad_d;
			width_q  <= width_d;
			height_q <= height_d;
			chars_q  <= chars_d;
			rbi_q    <= rbi_d;
			row_q    <= row_d;
		end
	end

endmodule

// ----- rtl/mbsd_out_fifo.sv -----
module mbsd_out_fifo (
	input  logic              clk,
	input  logic              arst_n,
	input  mbsd_pkg::push_t   push,
	output logic              room_two,
	output logic              out_valid,
	input  logic              out_ready,
	output mbsd_pkg::result_t out_res
);

	localparam int Depth = mbsd_pkg::FIFO_DEPTH;
	localparam int PTR_W = $clog2(Depth);

	mbsd_pkg::result_t  mem_q [Depth];
	logic [PTR_W-1:0]   wr_q;
	logic [PTR_W-1:0]   rd_q;
	logic [PTR_W:0]     cnt_q;
	logic               pop;

	assign out_valid = cnt_q != '0;
	assign out_res   = mem_q[rd_q];
	assign pop       = out_valid && out_ready;
	assign room_two  = cnt_q <= (PTR_W+1)'(Depth - 2);

	always_ff @(posedge clk) begin
		if (push.count != 2'd0) begin
			mem_q[wr_q] <= push.first;
		end
		if (push.count == 2'd2) begin
			mem_q[wr_q + PTR_W'(1)] <= push.second;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			wr_q  <= wr_q + PTR_W'(push.count);
			rd_q  <= rd_q + PTR_W'(pop);
			cnt_q <= cnt_q + (PTR_W+1)'(push.count) - (PTR_W+1)'(pop);
		end
	end

endmodule
